// ===== rtl/core/pstats_pkg.sv =====
`default_nettype none
package pstats_pkg;

   // default sizing, handed to the top level parameters
   localparam int DEF_TABLE_ENTRIES = 32;
   localparam int DEF_READING_CAP   = 256;

   // fixed field widths
   localparam int ADDR_W      = 32;
   localparam int PORT_W      = 16;
   localparam int KEY_W       = ADDR_W + PORT_W;
   localparam int TEMP_W      = 16;
   localparam int STATUS_W    = 2;
   localparam int COUNT_OUT_W = 9;
   localparam int REQ_DATA_W  = 64;
   localparam int RSP_DATA_W  = 64;
   localparam int RSP_PAD_W   = RSP_DATA_W - (STATUS_W + 3 * TEMP_W + COUNT_OUT_W);

   // alert level 35.0 degrees in 1/16 degree units
   localparam logic signed [TEMP_W-1:0] THRESHOLD_RESET = 16'sd560;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_NORMAL = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ALERT  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MISS,
      ST_UPDATE,
      ST_DIVIDE,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic start;
      logic scan_step;
      logic take_hit;
      logic alloc;
      logic set_full;
      logic update;
      logic div_step;
      logic load_rsp;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic hit;
      logic miss;
      logic table_full;
      logic div_last;
      logic rsp_free;
   } sts_type;

endpackage
`default_nettype wire

// ===== rtl/core/pstats_ram.sv =====
`default_nettype none
module pstats_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]      wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]      rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ===== rtl/core/pstats_ctrl.sv =====
`default_nettype none
module pstats_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire pstats_pkg::sts_type sts,
   output pstats_pkg::cmd_type      cmd
);

   pstats_pkg::state_type state_ff;
   pstats_pkg::state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pstats_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pstats_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = pstats_pkg::ST_SCAN;
            end
         end
         pstats_pkg::ST_SCAN: begin
            if (sts.hit) begin
               state_in = pstats_pkg::ST_UPDATE;
            end else if (sts.miss) begin
               state_in = pstats_pkg::ST_MISS;
            end
         end
         pstats_pkg::ST_MISS: begin
            if (sts.table_full) begin
               state_in = pstats_pkg::ST_DONE;
            end else begin
               state_in = pstats_pkg::ST_UPDATE;
            end
         end
         pstats_pkg::ST_UPDATE: begin
            state_in = pstats_pkg::ST_DIVIDE;
         end
         pstats_pkg::ST_DIVIDE: begin
            if (sts.div_last) begin
               state_in = pstats_pkg::ST_DONE;
            end
         end
         pstats_pkg::ST_DONE: begin
            if (sts.rsp_free) begin
               state_in = pstats_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pstats_pkg::ST_IDLE;
         end
      endcase
   end

   // commands
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         pstats_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.start  = req_tvalid;
         end
         pstats_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
            cmd.take_hit  = sts.hit;
         end
         pstats_pkg::ST_MISS: begin
            cmd.set_full = sts.table_full;
            cmd.alloc    = ~sts.table_full;
         end
         pstats_pkg::ST_UPDATE: begin
            cmd.update = 1'b1;
         end
         pstats_pkg::ST_DIVIDE: begin
            cmd.div_step = 1'b1;
         end
         pstats_pkg::ST_DONE: begin
            cmd.load_rsp = sts.rsp_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/core/pstats_datapath.sv =====
`default_nettype none
module pstats_datapath #(
   parameter int TABLE_ENTRIES = pstats_pkg::DEF_TABLE_ENTRIES,
   parameter int READING_CAP   = pstats_pkg::DEF_READING_CAP
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [pstats_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire logic                                csr_we,
   input  wire logic [pstats_pkg::TEMP_W-1:0]       csr_wdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic      [pstats_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  wire pstats_pkg::cmd_type                 cmd,
   output pstats_pkg::sts_type                      sts
);

   localparam int IDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int USED_W  = $clog2(TABLE_ENTRIES + 1);
   localparam int CNT_W   = $clog2(READING_CAP + 1);
   localparam int SUM_W   = pstats_pkg::TEMP_W + $clog2(READING_CAP);
   localparam int STEP_W  = $clog2(SUM_W + 1);
   localparam int T_W     = pstats_pkg::TEMP_W;
   localparam int ENTRY_W = pstats_pkg::KEY_W + SUM_W + 2 * T_W + CNT_W;

   // entry word layout, count in the low bits
   localparam int MAX_LSB = CNT_W;
   localparam int MIN_LSB = MAX_LSB + T_W;
   localparam int SUM_LSB = MIN_LSB + T_W;
   localparam int KEY_LSB = SUM_LSB + SUM_W;

   // request registers
   logic [pstats_pkg::KEY_W-1:0] key_ff, key_in;
   logic signed [T_W-1:0]        temp_ff, temp_in;
   logic signed [T_W-1:0]        thresh_ff, thresh_in;

   // table bookkeeping and scan
   logic [USED_W-1:0] used_ff, used_in;
   logic [USED_W-1:0] scan_cnt_ff, scan_cnt_in;
   logic              pend_ff, pend_in;
   logic [IDX_W-1:0]  slot_ff, slot_in;
   logic              full_ff, full_in;
   logic              alert_ff, alert_in;

   // working copy of the entry
   logic signed [SUM_W-1:0] e_sum_ff, e_sum_in;
   logic signed [T_W-1:0]   e_min_ff, e_min_in;
   logic signed [T_W-1:0]   e_max_ff, e_max_in;
   logic [CNT_W-1:0]        e_cnt_ff, e_cnt_in;

   // divider
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              neg_ff, neg_in;

   // response register
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [pstats_pkg::STATUS_W-1:0]      rsp_status_ff, rsp_status_in;
   logic signed [T_W-1:0]                rsp_mean_ff, rsp_mean_in;
   logic signed [T_W-1:0]                rsp_min_ff, rsp_min_in;
   logic signed [T_W-1:0]                rsp_max_ff, rsp_max_in;
   logic [pstats_pkg::COUNT_OUT_W-1:0]   rsp_cnt_ff, rsp_cnt_in;

   // memory ports
   logic [ENTRY_W-1:0] rd_entry;
   logic [ENTRY_W-1:0] wr_entry;
   logic [IDX_W-1:0]   rd_addr;

   // combinational helpers
   logic                    scan_more;
   logic                    key_match;
   logic                    can_store;
   logic signed [SUM_W-1:0] upd_sum;
   logic signed [T_W-1:0]   upd_min;
   logic signed [T_W-1:0]   upd_max;
   logic [CNT_W-1:0]        upd_cnt;
   logic [CNT_W:0]          rem_shift;
   logic [CNT_W:0]          rem_diff;
   logic                    quo_bit;
   logic [SUM_W-1:0]        quo_signed;
   logic                    rsp_free;

   pstats_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock (clock),
      .we    (cmd.update),
      .waddr (slot_ff),
      .wdata (wr_entry),
      .raddr (rd_addr),
      .rdata (rd_entry)
   );

   // key scan over the entries in use, one read a cycle, compare on the registered read data
   assign scan_more = scan_cnt_ff < used_ff;
   assign rd_addr   = scan_cnt_ff[IDX_W-1:0];
   assign key_match = rd_entry[KEY_LSB +: pstats_pkg::KEY_W] == key_ff;

   // statistics update for one reading
   always_comb begin
      can_store = e_cnt_ff < CNT_W'(READING_CAP);
      upd_sum   = e_sum_ff;
      upd_min   = e_min_ff;
      upd_max   = e_max_ff;
      upd_cnt   = e_cnt_ff;
      if (can_store) begin
         upd_sum = e_sum_ff + SUM_W'(temp_ff);
         upd_cnt = e_cnt_ff + CNT_W'(1);
         if (e_cnt_ff == '0) begin
            upd_min = temp_ff;
            upd_max = temp_ff;
         end else begin
            if (temp_ff < e_min_ff) begin
               upd_min = temp_ff;
            end
            if (temp_ff > e_max_ff) begin
               upd_max = temp_ff;
            end
         end
      end
   end

   assign wr_entry = {key_ff, upd_sum, upd_min, upd_max, upd_cnt};

   // restoring divide step on the magnitude of the sum
   assign rem_shift  = {rem_ff, quo_ff[SUM_W-1]};
   assign rem_diff   = rem_shift - {1'b0, e_cnt_ff};
   assign quo_bit    = rem_shift >= {1'b0, e_cnt_ff};
   assign quo_signed = neg_ff ? (~quo_ff + SUM_W'(1)) : quo_ff;

   assign rsp_free = ~rsp_valid_ff | rsp_tready;

   // next values
   always_comb begin
      key_in        = key_ff;
      temp_in       = temp_ff;
      thresh_in     = thresh_ff;
      used_in       = used_ff;
      scan_cnt_in   = scan_cnt_ff;
      pend_in       = pend_ff;
      slot_in       = slot_ff;
      full_in       = full_ff;
      alert_in      = alert_ff;
      e_sum_in      = e_sum_ff;
      e_min_in      = e_min_ff;
      e_max_in      = e_max_ff;
      e_cnt_in      = e_cnt_ff;
      quo_in        = quo_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      neg_in        = neg_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_mean_in   = rsp_mean_ff;
      rsp_min_in    = rsp_min_ff;
      rsp_max_in    = rsp_max_ff;
      rsp_cnt_in    = rsp_cnt_ff;

      // threshold register
      if (csr_we) begin
         thresh_in = csr_wdata;
      end

      // take the request
      if (cmd.start) begin
         key_in      = {req_tdata[pstats_pkg::ADDR_W-1:0],
                        req_tdata[pstats_pkg::KEY_W-1:pstats_pkg::ADDR_W]};
         temp_in     = req_tdata[pstats_pkg::KEY_W +: T_W];
         scan_cnt_in = '0;
         pend_in     = 1'b0;
         full_in     = 1'b0;
      end

      // scan step
      if (cmd.scan_step) begin
         pend_in = scan_more;
         if (scan_more) begin
            scan_cnt_in = scan_cnt_ff + USED_W'(1);
         end
      end

      // matching entry found
      if (cmd.take_hit) begin
         slot_in  = IDX_W'(scan_cnt_ff - USED_W'(1));
         e_sum_in = rd_entry[SUM_LSB +: SUM_W];
         e_min_in = rd_entry[MIN_LSB +: T_W];
         e_max_in = rd_entry[MAX_LSB +: T_W];
         e_cnt_in = rd_entry[CNT_W-1:0];
      end

      // new source gets the next entry
      if (cmd.alloc) begin
         slot_in  = used_ff[IDX_W-1:0];
         used_in  = used_ff + USED_W'(1);
         e_sum_in = '0;
         e_min_in = '0;
         e_max_in = '0;
         e_cnt_in = '0;
      end

      if (cmd.set_full) begin
         full_in = 1'b1;
      end

      // record reading, prime the divider
      if (cmd.update) begin
         e_sum_in = upd_sum;
         e_min_in = upd_min;
         e_max_in = upd_max;
         e_cnt_in = upd_cnt;
         alert_in = temp_ff > thresh_ff;
         neg_in   = upd_sum[SUM_W-1];
         quo_in   = upd_sum[SUM_W-1] ? (~upd_sum + SUM_W'(1)) : upd_sum;
         rem_in   = '0;
         step_in  = STEP_W'(SUM_W);
      end

      if (cmd.div_step) begin
         quo_in  = {quo_ff[SUM_W-2:0], quo_bit};
         rem_in  = quo_bit ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
         step_in = step_ff - STEP_W'(1);
      end

      // load the response register
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
         if (full_ff) begin
            rsp_status_in = pstats_pkg::STATUS_FULL;
            rsp_mean_in   = '0;
            rsp_min_in    = '0;
            rsp_max_in    = '0;
            rsp_cnt_in    = '0;
         end else begin
            rsp_status_in = alert_ff ? pstats_pkg::STATUS_ALERT : pstats_pkg::STATUS_NORMAL;
            rsp_mean_in   = quo_signed[T_W-1:0];
            rsp_min_in    = e_min_ff;
            rsp_max_in    = e_max_ff;
            rsp_cnt_in    = pstats_pkg::COUNT_OUT_W'(e_cnt_ff);
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff    <= pstats_pkg::THRESHOLD_RESET;
         used_ff      <= '0;
         scan_cnt_ff  <= '0;
         pend_ff      <= 1'b0;
         full_ff      <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         thresh_ff    <= thresh_in;
         used_ff      <= used_in;
         scan_cnt_ff  <= scan_cnt_in;
         pend_ff      <= pend_in;
         full_ff      <= full_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      temp_ff       <= temp_in;
      slot_ff       <= slot_in;
      alert_ff      <= alert_in;
      e_sum_ff      <= e_sum_in;
      e_min_ff      <= e_min_in;
      e_max_ff      <= e_max_in;
      e_cnt_ff      <= e_cnt_in;
      quo_ff        <= quo_in;
      rem_ff        <= rem_in;
      neg_ff        <= neg_in;
      rsp_status_ff <= rsp_status_in;
      rsp_mean_ff   <= rsp_mean_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_max_ff    <= rsp_max_in;
      rsp_cnt_ff    <= rsp_cnt_in;
   end

   // status to the controller
   assign sts.hit        = pend_ff & key_match;
   assign sts.miss       = ~pend_ff & ~scan_more;
   assign sts.table_full = used_ff == USED_W'(TABLE_ENTRIES);
   assign sts.div_last   = step_ff == STEP_W'(1);
   assign sts.rsp_free   = rsp_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{pstats_pkg::RSP_PAD_W{1'b0}}, rsp_cnt_ff, rsp_max_ff, rsp_min_ff,
                        rsp_mean_ff, rsp_status_ff};

endmodule
`default_nettype wire

// ===== rtl/core/per_source_temperature_stats.sv =====
// throughput: one request at a time; the key scan (one table read a cycle) and the
//   bit-serial divider (one quotient bit a cycle, 24 bits at default sizing) keep the block busy
// reset: synchronous, active high; clears the entry count, the control state and the
//   response valid, and loads the alert threshold with 560; table contents are not cleared
`default_nettype none
module per_source_temperature_stats #(
   parameter int TABLE_ENTRIES = pstats_pkg::DEF_TABLE_ENTRIES,
   parameter int READING_CAP   = pstats_pkg::DEF_READING_CAP
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // source_address [31:0], source_port [47:32], temperature [63:48]
   input  wire logic [pstats_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // status [1:0], mean_value [17:2], minimum_value [33:18], maximum_value [49:34],
   // reading_count [58:50]
   output logic      [pstats_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   input  wire logic                               csr_we,
   input  wire logic [pstats_pkg::TEMP_W-1:0]      csr_wdata
);

   pstats_pkg::cmd_type cmd;
   pstats_pkg::sts_type sts;

   pstats_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   pstats_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .READING_CAP   (READING_CAP)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .cmd        (cmd),
      .sts        (sts)
   );

   // a full table reports nothing recorded
   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] == pstats_pkg::STATUS_FULL) |->
      (rsp_tdata[58:2] == '0))
      else $error("table full response carries statistics");

   // the mean lies between the minimum and the maximum
   a_mean_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[1:0] != pstats_pkg::STATUS_FULL) |->
      ($signed(rsp_tdata[33:18]) <= $signed(rsp_tdata[17:2]) &&
       $signed(rsp_tdata[17:2]) <= $signed(rsp_tdata[49:34])))
      else $error("mean outside min/max range");

   // a taken request keeps the block busy on the next cycle
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request taken while previous request still in work");

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_SIZE    = pstats_pkg::DEF_TABLE_ENTRIES;
   localparam int CAP           = pstats_pkg::DEF_READING_CAP;
   localparam int LIMIT_CYCLES  = 400_000;
   localparam int DIRECTED_ROWS = 23;
   localparam int PHASES        = 6;
   localparam int PHASE_ITEMS   = 70;

   typedef struct packed {
      logic [pstats_pkg::STATUS_W-1:0]    status;
      logic [pstats_pkg::TEMP_W-1:0]      mean;
      logic [pstats_pkg::TEMP_W-1:0]      minimum;
      logic [pstats_pkg::TEMP_W-1:0]      maximum;
      logic [pstats_pkg::COUNT_OUT_W-1:0] count;
   } summary_type;

   typedef enum bit {ROW_READING, ROW_THRESHOLD} row_kind_type;

   typedef struct packed {
      row_kind_type                  kind;
      logic [pstats_pkg::ADDR_W-1:0] addr;
      logic [pstats_pkg::PORT_W-1:0] port;
      logic [pstats_pkg::TEMP_W-1:0] value;
      bit                            typed;
      summary_type                   want;
   } step_type;

   localparam summary_type NO_SUMMARY = '0;

   logic                              clock;
   logic                              reset;
   logic [pstats_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                              req_tvalid;
   logic                              req_tready;
   logic [pstats_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                              rsp_tvalid;
   logic                              rsp_tready;
   logic                              csr_we;
   logic [pstats_pkg::TEMP_W-1:0]     csr_wdata;

   per_source_temperature_stats DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   // per-source statistics table mirrored in the bench
   logic [pstats_pkg::KEY_W-1:0] src_key   [TABLE_SIZE];
   int                           src_sum   [TABLE_SIZE];
   int                           src_min   [TABLE_SIZE];
   int                           src_max   [TABLE_SIZE];
   int                           src_count [TABLE_SIZE];
   int                           sources_used = 0;
   int                           alert_level  = 560;

   summary_type pending_summaries [$];
   int          mismatches    = 0;
   bit          steady_sender = 0;
   step_type    directed_steps [DIRECTED_ROWS];

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit
   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("tb_top: done, errors");
      $finish;
   end

   // look up or allocate the source, fold in the reading, return the summary
   function automatic summary_type summarize_reading(logic [pstats_pkg::ADDR_W-1:0] addr,
                                                     logic [pstats_pkg::PORT_W-1:0] port,
                                                     logic [pstats_pkg::TEMP_W-1:0] temp);
      logic [pstats_pkg::KEY_W-1:0] key;
      int                           t;
      int                           slot;
      bit                           found;
      summary_type                  s;
      key   = {addr, port};
      t     = $signed(temp);
      slot  = 0;
      found = 0;
      for (int i = 0; i < sources_used; i++) begin
         if (!found && src_key[i] == key) begin
            slot  = i;
            found = 1;
         end
      end
      if (!found) begin
         if (sources_used >= TABLE_SIZE) begin
            s        = NO_SUMMARY;
            s.status = pstats_pkg::STATUS_FULL;
            return s;
         end
         slot            = sources_used;
         sources_used    = sources_used + 1;
         src_key[slot]   = key;
         src_sum[slot]   = 0;
         src_count[slot] = 0;
      end
      // readings past the cap only decide the alert
      if (src_count[slot] < CAP) begin
         if (src_count[slot] == 0) begin
            src_min[slot] = t;
            src_max[slot] = t;
         end else begin
            if (t < src_min[slot]) src_min[slot] = t;
            if (t > src_max[slot]) src_max[slot] = t;
         end
         src_sum[slot]   = src_sum[slot] + t;
         src_count[slot] = src_count[slot] + 1;
      end
      s.status  = (t > alert_level) ? pstats_pkg::STATUS_ALERT : pstats_pkg::STATUS_NORMAL;
      s.mean    = 16'(src_sum[slot] / src_count[slot]);
      s.minimum = 16'(src_min[slot]);
      s.maximum = 16'(src_max[slot]);
      s.count   = 9'(src_count[slot]);
      return s;
   endfunction

   function automatic int sender_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_sender || r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [pstats_pkg::TEMP_W-1:0] random_temperature();
      int r;
      int v;
      r = $urandom_range(0, 99);
      if (r < 10) return 16'h8000;
      if (r < 20) return 16'h7fff;
      if (r < 40) begin
         // around the alert level
         v = alert_level + int'($urandom_range(0, 4)) - 2;
         if (v > 32767) v = 32767;
         if (v < -32768) v = -32768;
         return 16'(v);
      end
      return 16'($urandom_range(0, 65535));
   endfunction

   function automatic void check_field(string name, int want, int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // one request, then the summary it should produce
   task automatic send_reading(logic [pstats_pkg::ADDR_W-1:0] addr,
                               logic [pstats_pkg::PORT_W-1:0] port,
                               logic [pstats_pkg::TEMP_W-1:0] temp, bit typed,
                               summary_type want);
      summary_type predicted;
      int          gap;
      gap = sender_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  = {temp, port, addr};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      predicted = summarize_reading(addr, port, temp);
      pending_summaries.push_back(typed ? want : predicted);
   endtask

   // threshold changes only with nothing in flight
   task automatic set_threshold(logic [pstats_pkg::TEMP_W-1:0] level);
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_summaries.size() != 0) @(negedge clock);
      csr_we      = 1'b1;
      csr_wdata   = level;
      alert_level = $signed(level);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // response back-pressure: short stalls, a few long ones, short and long ready stretches
   initial begin : response_stalls
      int hold;
      int r;
      rsp_tready = 1'b0;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               rsp_tready = 1'b1;
               hold = $urandom_range(0, 6);
            end else if (r < 85) begin
               rsp_tready = 1'b0;
               hold = $urandom_range(0, 3);
            end else if (r < 95) begin
               rsp_tready = 1'b1;
               hold = $urandom_range(40, 120);
            end else begin
               rsp_tready = 1'b0;
               hold = $urandom_range(10, 50);
            end
         end
      end
   end

   // response checker
   always @(posedge clock) begin : summary_check
      summary_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_summaries.size() == 0) begin
            $error("unexpected response %h", rsp_tdata);
            mismatches++;
         end else begin
            want = pending_summaries.pop_front();
            check_field("status", want.status, rsp_tdata[1:0]);
            check_field("mean_value", $signed(want.mean), $signed(rsp_tdata[17:2]));
            check_field("minimum_value", $signed(want.minimum), $signed(rsp_tdata[33:18]));
            check_field("maximum_value", $signed(want.maximum), $signed(rsp_tdata[49:34]));
            check_field("reading_count", want.count, rsp_tdata[58:50]);
            check_field("padding", 0, rsp_tdata[63:59]);
         end
      end
   end

   initial begin : stimulus
      logic [pstats_pkg::ADDR_W-1:0] addr;
      logic [pstats_pkg::PORT_W-1:0] port;
      logic [pstats_pkg::ADDR_W-1:0] hot_addr;
      logic [pstats_pkg::PORT_W-1:0] hot_port;
      logic [pstats_pkg::TEMP_W-1:0] phase_level;
      summary_type                   full_want;
      int                            r;
      int                            k;
      int                            hot_slot;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_we     = 1'b0;
      csr_wdata  = '0;

      // directed rows: extremes, threshold edges, truncation of negative means,
      // keys that share only the address or only the port
      directed_steps[0]  = '{ROW_READING, 32'h0000_0000, 16'h0000, 16'd560, 1'b1,
                             '{pstats_pkg::STATUS_NORMAL, 16'd560, 16'd560, 16'd560, 9'd1}};
      directed_steps[1]  = '{ROW_READING, 32'h0000_0000, 16'h0000, 16'd561, 1'b1,
                             '{pstats_pkg::STATUS_ALERT, 16'd560, 16'd560, 16'd561, 9'd2}};
      directed_steps[2]  = '{ROW_READING, 32'hffff_ffff, 16'hffff, 16'h8000, 1'b1,
                             '{pstats_pkg::STATUS_NORMAL, 16'h8000, 16'h8000, 16'h8000,
                               9'd1}};
      directed_steps[3]  = '{ROW_READING, 32'hffff_ffff, 16'hffff, 16'h7fff, 1'b1,
                             '{pstats_pkg::STATUS_ALERT, 16'd0, 16'h8000, 16'h7fff, 9'd2}};
      directed_steps[4]  = '{ROW_READING, 32'hffff_ffff, 16'hffff, 16'hffff, 1'b0,
                             NO_SUMMARY};
      directed_steps[5]  = '{ROW_READING, 32'h8000_0000, 16'h8000, -16'sd7, 1'b1,
                             '{pstats_pkg::STATUS_NORMAL, -16'sd7, -16'sd7, -16'sd7, 9'd1}};
      directed_steps[6]  = '{ROW_READING, 32'h8000_0000, 16'h8000, 16'd0, 1'b1,
                             '{pstats_pkg::STATUS_NORMAL, -16'sd3, -16'sd7, 16'd0, 9'd2}};
      directed_steps[7]  = '{ROW_READING, 32'h0000_0000, 16'h0001, 16'd100, 1'b1,
                             '{pstats_pkg::STATUS_NORMAL, 16'd100, 16'd100, 16'd100, 9'd1}};
      directed_steps[8]  = '{ROW_READING, 32'h0000_0001, 16'h0000, 16'd200, 1'b1,
                             '{pstats_pkg::STATUS_NORMAL, 16'd200, 16'd200, 16'd200, 9'd1}};
      directed_steps[9]  = '{ROW_READING, 32'h0000_0000, 16'h0000, 16'h8000, 1'b0,
                             NO_SUMMARY};
      directed_steps[10] = '{ROW_THRESHOLD, '0, '0, 16'h8000, 1'b0, NO_SUMMARY};
      directed_steps[11] = '{ROW_READING, 32'h8000_0000, 16'h8000, 16'h8001, 1'b0,
                             NO_SUMMARY};
      directed_steps[12] = '{ROW_READING, 32'h8000_0000, 16'h8000, 16'h8000, 1'b0,
                             NO_SUMMARY};
      directed_steps[13] = '{ROW_THRESHOLD, '0, '0, 16'h7fff, 1'b0, NO_SUMMARY};
      directed_steps[14] = '{ROW_READING, 32'hffff_ffff, 16'hffff, 16'h7fff, 1'b0,
                             NO_SUMMARY};
      directed_steps[15] = '{ROW_THRESHOLD, '0, '0, 16'd0, 1'b0, NO_SUMMARY};
      directed_steps[16] = '{ROW_READING, 32'h0000_0000, 16'h0001, 16'd1, 1'b0,
                             NO_SUMMARY};
      directed_steps[17] = '{ROW_READING, 32'h0000_0000, 16'h0001, 16'd0, 1'b0,
                             NO_SUMMARY};
      directed_steps[18] = '{ROW_READING, 32'h1234_5678, 16'habcd, 16'd0, 1'b1,
                             '{pstats_pkg::STATUS_NORMAL, 16'd0, 16'd0, 16'd0, 9'd1}};
      directed_steps[19] = '{ROW_THRESHOLD, '0, '0, 16'd560, 1'b0, NO_SUMMARY};
      directed_steps[20] = '{ROW_READING, 32'h0000_0001, 16'h0000, 16'h5555, 1'b0,
                             NO_SUMMARY};
      directed_steps[21] = '{ROW_READING, 32'h0000_0001, 16'h0000, 16'haaaa, 1'b0,
                             NO_SUMMARY};
      directed_steps[22] = '{ROW_READING, 32'h7fff_ffff, 16'h7fff, 16'd561, 1'b0,
                             NO_SUMMARY};

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == ROW_THRESHOLD)
            set_threshold(directed_steps[i].value);
         else
            send_reading(directed_steps[i].addr, directed_steps[i].port,
                         directed_steps[i].value, directed_steps[i].typed,
                         directed_steps[i].want);
      end

      // random phases: one busy source, known sources, known addresses on other ports, new sources
      hot_addr = $urandom;
      hot_port = 16'($urandom_range(0, 65535));
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: phase_level = 16'h7fff;
            1: phase_level = 16'h8000;
            2: phase_level = 16'd0;
            4: phase_level = 16'd560;
            default: phase_level = 16'($urandom_range(0, 65535));
         endcase
         set_threshold(phase_level);
         steady_sender = (ph == 2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            if ((ph == 0 && n == 0) || r < 55) begin
               addr = hot_addr;
               port = hot_port;
            end else if (r < 83 && sources_used > 0) begin
               k = $urandom_range(0, sources_used - 1);
               {addr, port} = src_key[k];
            end else if (r < 88 && sources_used > 0) begin
               // known address, other port
               k = $urandom_range(0, sources_used - 1);
               addr = src_key[k][pstats_pkg::KEY_W-1:pstats_pkg::PORT_W];
               port = 16'($urandom_range(0, 65535));
            end else begin
               addr = $urandom;
               port = 16'($urandom_range(0, 65535));
            end
            send_reading(addr, port, random_temperature(), 1'b0, NO_SUMMARY);
         end
      end
      steady_sender = 1'b0;

      // make sure the table is full and the busy source has hit its cap
      while (sources_used < TABLE_SIZE)
         send_reading($urandom, 16'($urandom_range(0, 65535)), random_temperature(),
                      1'b0, NO_SUMMARY);
      hot_slot = 0;
      for (int i = 0; i < sources_used; i++)
         if (src_key[i] == {hot_addr, hot_port}) hot_slot = i;
      while (src_count[hot_slot] < CAP)
         send_reading(hot_addr, hot_port, random_temperature(), 1'b0, NO_SUMMARY);

      // unknown source on a full table records nothing
      full_want        = NO_SUMMARY;
      full_want.status = pstats_pkg::STATUS_FULL;
      send_reading($urandom, 16'($urandom_range(0, 65535)), 16'h7fff, 1'b1, full_want);
      // past the cap: statistics frozen, alert still follows the reading
      send_reading(hot_addr, hot_port, 16'h7fff, 1'b0, NO_SUMMARY);
      send_reading(hot_addr, hot_port, 16'h8000, 1'b0, NO_SUMMARY);

      // drain, then allow for a stray late response
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_summaries.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);

      if (mismatches == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule
`default_nettype wire
